@@ hdl/bcc_pkg.sv @@
// Shared constants and types for the bandpass complex calibration block.
package bcc_pkg;

  // Default sample width and fixed output format
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int FRAC_BITS        = 16;
  localparam int CAL_WIDTH        = 32;

  // Saturation limits of the Q16.16 outputs, as raw words
  localparam logic [CAL_WIDTH-1:0] CAL_POS_MAX = {1'b0, {(CAL_WIDTH-1){1'b1}}};
  localparam logic [CAL_WIDTH-1:0] CAL_NEG_MAX = {1'b1, {(CAL_WIDTH-1){1'b0}}};

  // Status of one serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ hdl/bcc_sqsum.sv @@
// Bit-serial sum of two squares, one multiplier bit per cycle.
module bcc_sqsum #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [W-1:0]         a,
  input  logic [W-1:0]         b,
  output bcc_pkg::unit_stat_t  stat,
  output logic [2*W-1:0]       sum_sq
);
  import bcc_pkg::*;

  localparam int CW = $clog2(W);

  logic [W-1:0]   a_q;
  logic [W-1:0]   b_q;
  logic [W-1:0]   ma;
  logic [W-1:0]   mb;
  logic [W:0]     acc_hi;
  logic [W-1:0]   acc_lo;
  logic [CW-1:0]  cnt;
  logic [W+1:0]   step_sum;

  // Add both partial products selected by the low multiplier bits
  always_comb begin
    step_sum = {1'b0, acc_hi}
             + (ma[0] ? {2'b00, a_q} : '0)
             + (mb[0] ? {2'b00, b_q} : '0);
  end

  // Sequence W steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Shift the accumulator right, product bits fall into the low word
  always_ff @(posedge clk) begin
    if (start) begin
      a_q    <= a;
      b_q    <= b;
      ma     <= a;
      mb     <= b;
      acc_hi <= '0;
      acc_lo <= '0;
    end else if (stat.busy) begin
      acc_hi <= step_sum[W+1:1];
      acc_lo <= {step_sum[0], acc_lo[W-1:1]};
      ma     <= ma >> 1;
      mb     <= mb >> 1;
    end
  end

  assign sum_sq = {acc_hi[W-1:0], acc_lo};

endmodule

@@ hdl/bcc_dotmul.sv @@
// Bit-serial complex products V*conj(B), one multiplier bit per cycle.
module bcc_dotmul #(
  parameter int SW = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [SW-1:0] vr,
  input  logic signed [SW-1:0] vi,
  input  logic signed [SW-1:0] br,
  input  logic signed [SW-1:0] bi,
  output bcc_pkg::unit_stat_t  stat,
  output logic                 re_neg,
  output logic [2*SW-1:0]      re_mag,
  output logic                 im_neg,
  output logic [2*SW-1:0]      im_mag
);
  import bcc_pkg::*;

  localparam int CW = $clog2(SW);
  localparam int AW = SW + 3;

  logic signed [SW:0]     vr_x;
  logic signed [SW:0]     vi_x;
  logic signed [SW:0]     pr_x;
  logic signed [SW:0]     pi_x;
  logic signed [SW:0]     qr_x;
  logic signed [SW:0]     qi_x;
  logic [SW-1:0]          mr;
  logic [SW-1:0]          mi;
  logic signed [SW+1:0]   re_hi;
  logic signed [SW+1:0]   im_hi;
  logic [SW-1:0]          re_lo;
  logic [SW-1:0]          im_lo;
  logic signed [AW-1:0]   re_sum;
  logic signed [AW-1:0]   im_sum;
  logic [CW-1:0]          cnt;
  logic signed [2*SW+1:0] re_full;
  logic signed [2*SW+1:0] im_full;
  logic [2*SW+1:0]        re_abs;
  logic [2*SW+1:0]        im_abs;

  assign vr_x = (SW+1)'(vr);
  assign vi_x = (SW+1)'(vi);

  // re += |br|*vr*sgn(br) + |bi|*vi*sgn(bi); im += |br|*vi*sgn(br) - |bi|*vr*sgn(bi)
  always_comb begin
    re_sum = AW'(re_hi) + (mr[0] ? AW'(pr_x) : '0) + (mi[0] ? AW'(qi_x) : '0);
    im_sum = AW'(im_hi) + (mr[0] ? AW'(pi_x) : '0) - (mi[0] ? AW'(qr_x) : '0);
  end

  // Sequence SW steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(SW - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Load sign-folded multiplicands, then shift-accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      pr_x  <= br[SW-1] ? -vr_x : vr_x;
      pi_x  <= br[SW-1] ? -vi_x : vi_x;
      qr_x  <= bi[SW-1] ? -vr_x : vr_x;
      qi_x  <= bi[SW-1] ? -vi_x : vi_x;
      mr    <= br[SW-1] ? (~br + 1'b1) : br;
      mi    <= bi[SW-1] ? (~bi + 1'b1) : bi;
      re_hi <= '0;
      im_hi <= '0;
      re_lo <= '0;
      im_lo <= '0;
    end else if (stat.busy) begin
      re_hi <= re_sum[AW-1:1];
      im_hi <= im_sum[AW-1:1];
      re_lo <= {re_sum[0], re_lo[SW-1:1]};
      im_lo <= {im_sum[0], im_lo[SW-1:1]};
      mr    <= mr >> 1;
      mi    <= mi >> 1;
    end
  end

  // Split the products into sign and magnitude
  assign re_full = {re_hi, re_lo};
  assign im_full = {im_hi, im_lo};
  assign re_neg  = re_full[2*SW+1];
  assign im_neg  = im_full[2*SW+1];
  assign re_abs  = re_neg ? -re_full : re_full;
  assign im_abs  = im_neg ? -im_full : im_full;
  assign re_mag  = re_abs[2*SW-1:0];
  assign im_mag  = im_abs[2*SW-1:0];

endmodule

@@ hdl/bcc_divider.sv @@
// Radix-2 restoring divider giving a saturated signed Q16.16 quotient.
module bcc_divider #(
  parameter int NW = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 neg,
  input  logic [NW-1:0]                        mag,
  input  logic [NW-1:0]                        den,
  output bcc_pkg::unit_stat_t                  stat,
  output logic signed [bcc_pkg::CAL_WIDTH-1:0] quot
);
  import bcc_pkg::*;

  localparam int CW = $clog2(CAL_WIDTH);

  logic [NW-1:0]        rem;
  logic [NW-1:0]        den_q;
  logic [CAL_WIDTH-1:0] num;
  logic [CAL_WIDTH-1:0] q;
  logic                 ovf;
  logic                 neg_q;
  logic [CW-1:0]        cnt;
  logic [NW:0]          part;
  logic [NW+1:0]        diff;
  logic                 ge;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    part = {rem, num[CAL_WIDTH-1]};
    diff = {1'b0, part} - {2'b00, den_q};
    ge   = ~diff[NW+1];
  end

  // Sequence one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(CAL_WIDTH - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Integer part above the output range saturates; else develop 32 bits
  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      neg_q <= neg;
      ovf   <= (mag >> FRAC_BITS) >= den;
      rem   <= mag >> FRAC_BITS;
      num   <= {mag[FRAC_BITS-1:0], {(CAL_WIDTH-FRAC_BITS){1'b0}}};
      q     <= '0;
    end else if (stat.busy) begin
      rem <= ge ? diff[NW-1:0] : part[NW-1:0];
      num <= num << 1;
      q   <= {q[CAL_WIDTH-2:0], ge};
    end
  end

  // Apply sign and clamp to the signed 32-bit range
  always_comb begin
    if (neg_q) begin
      quot = (ovf || q > CAL_NEG_MAX) ? CAL_NEG_MAX : -q;
    end else begin
      quot = (ovf || q > CAL_POS_MAX) ? CAL_POS_MAX : q;
    end
  end

endmodule

@@ hdl/bcc_isqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module bcc_isqrt #(
  parameter int RW = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2*RW-1:0]     x,
  output bcc_pkg::unit_stat_t stat,
  output logic [RW-1:0]       root
);
  import bcc_pkg::*;

  localparam int CW = $clog2(RW);

  logic [2*RW-1:0] xs;
  logic [RW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic [RW+3:0]   part;
  logic [RW+4:0]   diff;
  logic            ge;

  // Bring down two radicand bits and try 4*root+1
  always_comb begin
    part = {rem, xs[2*RW-1:2*RW-2]};
    diff = {1'b0, part} - {3'b000, root, 2'b01};
    ge   = ~diff[RW+4];
  end

  // Sequence RW steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(RW - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Keep the remainder when the trial fits, shift in the root bit
  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
    end else if (stat.busy) begin
      xs   <= xs << 2;
      rem  <= ge ? diff[RW+1:0] : part[RW+1:0];
      root <= {root[RW-2:0], ge};
    end
  end

endmodule

@@ hdl/bandpass_complex_calibrate_core.sv @@
// Four serial passes of 32 steps each (power and cross products, two parallel
// dividers, sum of squares, square root); a zero bandpass skips all but the first.
// One word at a time: the next input is taken in the cycle after a result is
// registered, while that result may still wait at the output.
// Reset: rst (synchronous) clears the sequencer, output valid and the running peak.
module bandpass_complex_calibrate_core #(
  parameter int SAMPLE_WIDTH = bcc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 vis_valid,
  output logic                                 vis_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]       vis_re,
  input  logic signed [SAMPLE_WIDTH-1:0]       vis_im,
  input  logic signed [SAMPLE_WIDTH-1:0]       band_re,
  input  logic signed [SAMPLE_WIDTH-1:0]       band_im,
  input  logic                                 last_channel,
  output logic                                 cal_valid,
  input  logic                                 cal_ready,
  output logic signed [bcc_pkg::CAL_WIDTH-1:0] cal_re,
  output logic signed [bcc_pkg::CAL_WIDTH-1:0] cal_im,
  output logic [bcc_pkg::CAL_WIDTH-1:0]        amplitude,
  output logic [bcc_pkg::CAL_WIDTH-1:0]        peak_amplitude,
  output logic                                 zero_band,
  output logic                                 spectrum_end
);
  import bcc_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int SQ_W = (SW > CAL_WIDTH) ? SW : CAL_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SQ,
    ST_ROOT,
    ST_DONE
  } state_t;

  state_t               state;
  logic                 mul_start;
  logic                 div_start;
  logic                 sq_start;
  logic                 root_start;
  logic signed [SW-1:0] vr_q;
  logic signed [SW-1:0] vi_q;
  logic signed [SW-1:0] br_q;
  logic signed [SW-1:0] bi_q;
  logic                 last_q;
  logic                 zero_q;
  logic [CAL_WIDTH-1:0] running_peak;

  unit_stat_t           sq_stat;
  unit_stat_t           dot_stat;
  unit_stat_t           div_re_stat;
  unit_stat_t           div_im_stat;
  unit_stat_t           root_stat;

  logic [SW-1:0]        br_mag;
  logic [SW-1:0]        bi_mag;
  logic [CAL_WIDTH-1:0] cre_mag;
  logic [CAL_WIDTH-1:0] cim_mag;
  logic [SQ_W-1:0]      sq_a;
  logic [SQ_W-1:0]      sq_b;
  logic [2*SQ_W-1:0]    sq_sum;
  logic                 dot_re_neg;
  logic                 dot_im_neg;
  logic [2*SW-1:0]      dot_re_mag;
  logic [2*SW-1:0]      dot_im_mag;
  logic [2*SW-1:0]      power;
  logic signed [CAL_WIDTH-1:0] quot_re;
  logic signed [CAL_WIDTH-1:0] quot_im;
  logic [SQ_W-1:0]      root;

  logic signed [CAL_WIDTH-1:0] cal_re_next;
  logic signed [CAL_WIDTH-1:0] cal_im_next;
  logic [CAL_WIDTH-1:0] amp_next;
  logic [CAL_WIDTH-1:0] peak_next;

  // Magnitudes feeding the sum-of-squares unit
  assign br_mag  = br_q[SW-1] ? (~br_q + 1'b1) : br_q;
  assign bi_mag  = bi_q[SW-1] ? (~bi_q + 1'b1) : bi_q;
  assign cre_mag = quot_re[CAL_WIDTH-1] ? (~quot_re + 1'b1) : quot_re;
  assign cim_mag = quot_im[CAL_WIDTH-1] ? (~quot_im + 1'b1) : quot_im;

  // Share the squaring unit: bandpass power first, then result power
  assign sq_a  = (state == ST_MUL) ? SQ_W'(br_mag) : SQ_W'(cre_mag);
  assign sq_b  = (state == ST_MUL) ? SQ_W'(bi_mag) : SQ_W'(cim_mag);
  assign power = sq_sum[2*SW-1:0];

  bcc_sqsum #(
    .W (SQ_W)
  ) u_sqsum (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start | sq_start),
    .a      (sq_a),
    .b      (sq_b),
    .stat   (sq_stat),
    .sum_sq (sq_sum)
  );

  bcc_dotmul #(
    .SW (SW)
  ) u_dotmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .vr     (vr_q),
    .vi     (vi_q),
    .br     (br_q),
    .bi     (bi_q),
    .stat   (dot_stat),
    .re_neg (dot_re_neg),
    .re_mag (dot_re_mag),
    .im_neg (dot_im_neg),
    .im_mag (dot_im_mag)
  );

  bcc_divider #(
    .NW (2*SW)
  ) u_div_re (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .neg   (dot_re_neg),
    .mag   (dot_re_mag),
    .den   (power),
    .stat  (div_re_stat),
    .quot  (quot_re)
  );

  bcc_divider #(
    .NW (2*SW)
  ) u_div_im (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .neg   (dot_im_neg),
    .mag   (dot_im_mag),
    .den   (power),
    .stat  (div_im_stat),
    .quot  (quot_im)
  );

  bcc_isqrt #(
    .RW (SQ_W)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .x     (sq_sum),
    .stat  (root_stat),
    .root  (root)
  );

  // Force zero results for a zero bandpass, fold amplitude into the peak
  always_comb begin
    cal_re_next = zero_q ? '0 : quot_re;
    cal_im_next = zero_q ? '0 : quot_im;
    amp_next    = zero_q ? '0 : root[CAL_WIDTH-1:0];
    peak_next   = (amp_next > running_peak) ? amp_next : running_peak;
  end

  assign vis_ready = (state == ST_IDLE);

  // Sequencer, input capture, running peak and output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mul_start    <= 1'b0;
      div_start    <= 1'b0;
      sq_start     <= 1'b0;
      root_start   <= 1'b0;
      cal_valid    <= 1'b0;
      running_peak <= '0;
    end else begin
      mul_start  <= 1'b0;
      div_start  <= 1'b0;
      sq_start   <= 1'b0;
      root_start <= 1'b0;
      // Drop the taken word unless the done state replaces it
      if (cal_valid && cal_ready && state != ST_DONE) begin
        cal_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (vis_valid) begin
            vr_q      <= vis_re;
            vi_q      <= vis_im;
            br_q      <= band_re;
            bi_q      <= band_im;
            last_q    <= last_channel;
            mul_start <= 1'b1;
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (sq_stat.done) begin
            if (power == '0) begin
              zero_q <= 1'b1;
              state  <= ST_DONE;
            end else begin
              zero_q    <= 1'b0;
              div_start <= 1'b1;
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_re_stat.done) begin
            sq_start <= 1'b1;
            state    <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (sq_stat.done) begin
            root_start <= 1'b1;
            state      <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_stat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!cal_valid || cal_ready) begin
            cal_re         <= cal_re_next;
            cal_im         <= cal_im_next;
            amplitude      <= amp_next;
            peak_amplitude <= peak_next;
            zero_band      <= zero_q;
            spectrum_end   <= last_q;
            cal_valid      <= 1'b1;
            running_peak   <= last_q ? '0 : peak_next;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The squaring unit only finishes while the sequencer waits for it
  a_sq_done_expected: assert property (@(posedge clk) disable iff (rst)
    sq_stat.done |-> (state == ST_MUL || state == ST_SQ))
    else $error("squaring unit finished outside a wait state");

  // Cross products are complete by the time the power is known
  a_dot_before_power: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && sq_stat.done) |-> !dot_stat.busy)
    else $error("cross products still busy when power is ready");

  // Both dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_re_stat.done |-> div_im_stat.done)
    else $error("real and imaginary dividers out of step");

  // A presented word never shows a peak below its own amplitude
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    cal_valid |-> (peak_amplitude >= amplitude))
    else $error("peak amplitude below word amplitude");

endmodule

@@ tb/bandpass_complex_calibrate_core_test.sv @@
`timescale 1ns / 1ps
// Testbench for the bandpass calibration core: directed channel table plus random channels.
module bandpass_complex_calibrate_core_test;
  import bcc_pkg::*;

  localparam int SW               = SAMPLE_WIDTH_DEF;
  localparam int WIDE             = 128;
  localparam int RANDOM_PER_PHASE = 670;
  localparam int LIGHT_IDLE       = 13;
  localparam int HEAVY_IDLE       = 65;
  localparam int HOLD_AT          = 60;
  localparam int HOLD_CYCLES      = 1500;
  localparam int DRAIN_CYCLES     = 200;
  localparam int CYCLE_LIMIT      = 2000000;
  localparam int MAX_REPORTS      = 10;
  localparam int RESET_CYCLES     = 7;

  localparam logic signed [SW-1:0] S_MAX   = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN   = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_ONE   = SW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] S_TWO   = SW'(2) << FRAC_BITS;
  localparam logic signed [SW-1:0] S_THREE = SW'(3) << FRAC_BITS;

  typedef struct {
    logic signed [SW-1:0] vis_re;
    logic signed [SW-1:0] vis_im;
    logic signed [SW-1:0] band_re;
    logic signed [SW-1:0] band_im;
    logic                 last;
  } channel_t;

  typedef struct {
    logic [CAL_WIDTH-1:0] re;
    logic [CAL_WIDTH-1:0] im;
    logic [CAL_WIDTH-1:0] amp;
    logic [CAL_WIDTH-1:0] peak;
    logic                 zero;
    logic                 last;
  } cal_t;

  typedef struct {
    channel_t chan;
    bit       typed;
    cal_t     want;
  } table_row_t;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        vis_valid    = 1'b0;
  logic                        vis_ready;
  logic signed [SW-1:0]        vis_re       = '0;
  logic signed [SW-1:0]        vis_im       = '0;
  logic signed [SW-1:0]        band_re      = '0;
  logic signed [SW-1:0]        band_im      = '0;
  logic                        last_channel = 1'b0;
  logic                        cal_valid;
  logic                        cal_ready    = 1'b0;
  logic signed [CAL_WIDTH-1:0] cal_re;
  logic signed [CAL_WIDTH-1:0] cal_im;
  logic [CAL_WIDTH-1:0]        amplitude;
  logic [CAL_WIDTH-1:0]        peak_amplitude;
  logic                        zero_band;
  logic                        spectrum_end;

  logic [CAL_WIDTH-1:0] spectrum_peak = '0;
  cal_t                 pending_cal [$];
  int                   mismatch_count = 0;
  int                   words_checked  = 0;
  int                   recv_idle_pct  = 0;
  int                   hold_left      = 0;
  bit                   hold_done      = 1'b0;
  int                   cycle_count    = 0;

  // Directed channels; expectations typed in only where they are obvious
  table_row_t dir_table [20] = '{
    '{'{S_MAX, S_MIN, 0, 0, 1'b0}, 1'b1, '{0, 0, 0, 0, 1'b1, 1'b0}},
    '{'{S_ONE, 0, S_ONE, 0, 1'b0}, 1'b1, '{'h10000, 0, 'h10000, 'h10000, 1'b0, 1'b0}},
    '{'{0, S_ONE, S_ONE, 0, 1'b0}, 1'b1, '{0, 'h10000, 'h10000, 'h10000, 1'b0, 1'b0}},
    '{'{S_ONE, 0, 0, S_ONE, 1'b0}, 1'b1, '{0, 'hFFFF0000, 'h10000, 'h10000, 1'b0, 1'b0}},
    '{'{S_MAX, 0, 1, 0, 1'b0}, 1'b1,
      '{CAL_POS_MAX, 0, CAL_POS_MAX, CAL_POS_MAX, 1'b0, 1'b0}},
    '{'{S_MIN, 0, 1, 0, 1'b0}, 1'b1,
      '{CAL_NEG_MAX, 0, CAL_NEG_MAX, CAL_NEG_MAX, 1'b0, 1'b0}},
    '{'{S_MIN, S_MIN, 1, 0, 1'b0}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{S_MAX, S_MAX, S_MIN, S_MIN, 1'b0}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{S_MIN, S_MIN, S_MIN, S_MIN, 1'b0}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{S_ONE, S_ONE, 0, 0, 1'b1}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{S_TWO, 0, S_ONE, 0, 1'b0}, 1'b1, '{'h20000, 0, 'h20000, 'h20000, 1'b0, 1'b0}},
    '{'{S_ONE, 0, S_TWO, 0, 1'b0}, 1'b1, '{'h8000, 0, 'h8000, 'h20000, 1'b0, 1'b0}},
    '{'{-S_ONE, 0, S_THREE, 0, 1'b0}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{1, 1, S_MAX, S_MAX, 1'b0}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{S_MAX, S_MIN, S_MIN, 0, 1'b0}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{S_ONE, 0, S_ONE, 0, 1'b1}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{0, 0, S_ONE, 0, 1'b1}, 1'b1, '{0, 0, 0, 0, 1'b0, 1'b1}},
    '{'{-1, -1, 0, -1, 1'b0}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{'h5A5A5A, -'h123456, 'h100, -'h300, 1'b0}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}},
    '{'{0, 0, 0, 0, 1'b1}, 1'b0, '{0, 0, 0, 0, 1'b0, 1'b0}}
  };

  bandpass_complex_calibrate_core #(
    .SAMPLE_WIDTH(SW)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .vis_valid     (vis_valid),
    .vis_ready     (vis_ready),
    .vis_re        (vis_re),
    .vis_im        (vis_im),
    .band_re       (band_re),
    .band_im       (band_im),
    .last_channel  (last_channel),
    .cal_valid     (cal_valid),
    .cal_ready     (cal_ready),
    .cal_re        (cal_re),
    .cal_im        (cal_im),
    .amplitude     (amplitude),
    .peak_amplitude(peak_amplitude),
    .zero_band     (zero_band),
    .spectrum_end  (spectrum_end)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Truncate num/den toward zero to Q16.16, then saturate to the output range
  function automatic logic [CAL_WIDTH-1:0] quotient_q16(logic signed [WIDE-1:0] num,
                                                        logic [WIDE-1:0] den);
    logic [WIDE-1:0] mag;
    logic [WIDE-1:0] q;
    mag = (num < 0) ? WIDE'(-num) : WIDE'(num);
    q = (mag << FRAC_BITS) / den;
    if (num < 0) begin
      if (q > WIDE'(CAL_NEG_MAX)) q = WIDE'(CAL_NEG_MAX);
      return -q[CAL_WIDTH-1:0];
    end
    if (q > WIDE'(CAL_POS_MAX)) q = WIDE'(CAL_POS_MAX);
    return q[CAL_WIDTH-1:0];
  endfunction

  // Build the root one bit at a time, keeping each bit whose square still fits
  function automatic logic [CAL_WIDTH-1:0] floor_sqrt(logic [WIDE-1:0] x);
    logic [CAL_WIDTH-1:0] root;
    logic [CAL_WIDTH-1:0] trial;
    root = '0;
    for (int b = CAL_WIDTH - 1; b >= 0; b--) begin
      trial = root | (CAL_WIDTH'(1) << b);
      if (WIDE'(trial) * WIDE'(trial) <= x) root = trial;
    end
    return root;
  endfunction

  // Divide one channel by its bandpass and advance the spectrum peak
  function automatic cal_t calibrate_channel(channel_t c);
    logic signed [WIDE-1:0] vr, vi, br, bi, sre, sim;
    logic [WIDE-1:0]        power;
    cal_t                   r;
    vr = c.vis_re;
    vi = c.vis_im;
    br = c.band_re;
    bi = c.band_im;
    power = WIDE'(br * br + bi * bi);
    r.zero = (power == 0);
    r.last = c.last;
    if (r.zero) begin
      r.re  = '0;
      r.im  = '0;
      r.amp = '0;
    end else begin
      r.re  = quotient_q16(vr * br + vi * bi, power);
      r.im  = quotient_q16(vi * br - vr * bi, power);
      sre   = $signed(r.re);
      sim   = $signed(r.im);
      r.amp = floor_sqrt(WIDE'(sre * sre + sim * sim));
    end
    if (r.amp > spectrum_peak) spectrum_peak = r.amp;
    r.peak = spectrum_peak;
    if (c.last) spectrum_peak = '0;
    return r;
  endfunction

  // Mix extremes, values near unity and full-range words
  function automatic logic signed [SW-1:0] random_sample();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = S_MAX;
          1: v = S_MIN;
          2: v = 0;
          3: v = 1;
          default: v = '1;
        endcase
      end
      1, 2, 3: begin
        v = $urandom_range(0, 32'h3FFFF);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom();
    endcase
    return v[SW-1:0];
  endfunction

  // Random channel with some zero, one-sided and tiny bandpass values
  function automatic channel_t random_channel();
    channel_t c;
    c.vis_re = random_sample();
    c.vis_im = random_sample();
    case ($urandom_range(0, 15))
      0: begin
        c.band_re = '0;
        c.band_im = '0;
      end
      1: begin
        c.band_re = random_sample();
        c.band_im = '0;
      end
      2: begin
        c.band_re = '0;
        c.band_im = random_sample();
      end
      3: begin
        c.band_re = SW'($urandom_range(0, 63)) - SW'(32);
        c.band_im = SW'($urandom_range(0, 63)) - SW'(32);
      end
      default: begin
        c.band_re = random_sample();
        c.band_im = random_sample();
      end
    endcase
    c.last = ($urandom_range(0, 15) == 0);
    return c;
  endfunction

  // Offer one channel word after a random gap, then record its expected result
  task automatic send_channel(channel_t c, bit typed, cal_t want, int idle_pct);
    int   gap;
    cal_t predicted;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      vis_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vis_valid    <= 1'b1;
    vis_re       <= c.vis_re;
    vis_im       <= c.vis_im;
    band_re      <= c.band_re;
    band_im      <= c.band_im;
    last_channel <= c.last;
    do @(posedge clk); while (!vis_ready);
    predicted = calibrate_channel(c);
    pending_cal.push_back(typed ? want : predicted);
  endtask

  // Compare one accepted result word with the oldest expectation
  task automatic check_word();
    cal_t e;
    words_checked++;
    if (pending_cal.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("unexpected result word: re %h im %h amp %h", cal_re, cal_im, amplitude);
      return;
    end
    e = pending_cal.pop_front();
    if (cal_re !== e.re || cal_im !== e.im || amplitude !== e.amp ||
        peak_amplitude !== e.peak || zero_band !== e.zero || spectrum_end !== e.last) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("word %0d expected: re %h im %h amp %h peak %h zero %b end %b",
                 words_checked, e.re, e.im, e.amp, e.peak, e.zero, e.last);
        $display("word %0d actual:   re %h im %h amp %h peak %h zero %b end %b",
                 words_checked, cal_re, cal_im, amplitude, peak_amplitude,
                 zero_band, spectrum_end);
      end
    end
  endtask

  // Result side: check accepted words, throttle ready, hold off once for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      cal_ready <= 1'b0;
    end else begin
      if (cal_valid && cal_ready) check_word();
      if (!hold_done && words_checked >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        cal_ready <= 1'b0;
      end else begin
        cal_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Input side: reset, directed table, three random phases, then drain
  initial begin : stimulus
    int   send_idle;
    cal_t no_want;
    no_want = '{default: '0};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    send_idle = LIGHT_IDLE;
    recv_idle_pct <= HEAVY_IDLE;
    foreach (dir_table[i])
      send_channel(dir_table[i].chan, dir_table[i].typed, dir_table[i].want, send_idle);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? LIGHT_IDLE : (phase == 1) ? HEAVY_IDLE : 0;
      recv_idle_pct <= (phase == 0) ? HEAVY_IDLE : (phase == 1) ? LIGHT_IDLE : 0;
      repeat (RANDOM_PER_PHASE) send_channel(random_channel(), 1'b0, no_want, send_idle);
    end
    vis_valid <= 1'b0;
    while (pending_cal.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_cal.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
